// ===== rtl/core/ibs_pkg.sv =====
// Shared constants and types for the 4x4 image binning block.
// No dependencies; every other file of the block but ibs_ram refers to it by scoped names.
package ibs_pkg;

   localparam int MAX_BINNED_WIDTH_DEF = 512;
   localparam int HEIGHT_LIMIT         = 512;

   // 4x4 blocks: two low bits of a pixel position give the place in the block
   localparam int BIN_SHIFT = 2;
   localparam logic [BIN_SHIFT-1:0] BIN_FIRST = 2'd0;
   localparam logic [BIN_SHIFT-1:0] BIN_LAST  = 2'd3;

   localparam int PIXEL_W  = 16;
   localparam int GROUP_W  = 18;
   localparam int SUM_W    = 20;
   localparam int POS_W    = 9;
   localparam int BRIGHT_W = 38;
   localparam int CFG_W    = 10;
   localparam int ROW_W    = 11;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from paddr[2]
   localparam logic REG_BINNED_WIDTH  = 1'b0;
   localparam logic REG_BINNED_HEIGHT = 1'b1;

   typedef struct packed {
      logic             emit;
      logic             last;
      logic [SUM_W-1:0] acc;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
   } stage_type;

endpackage

// ===== rtl/core/ibs_req_if.sv =====
// Pixel input channel: valid/ready handshake with one 16-bit pixel per word.
// Depends on ibs_pkg for the pixel width.
interface ibs_req_if;
   logic                         valid;
   logic                         ready;
   logic [ibs_pkg::PIXEL_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/core/ibs_rsp_if.sv =====
// Bin result channel: valid/ready handshake with the block sum, its position,
// the running frame brightness and the last-bin flag. Depends on ibs_pkg.
interface ibs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ibs_pkg::SUM_W-1:0]     bin_sum;
   logic [ibs_pkg::POS_W-1:0]     bin_column;
   logic [ibs_pkg::POS_W-1:0]     bin_row;
   logic [ibs_pkg::BRIGHT_W-1:0]  frame_brightness;
   logic                          last_bin;

   modport source (output valid, output bin_sum, output bin_column, output bin_row,
                   output frame_brightness, output last_bin, input ready);
   modport sink   (input valid, input bin_sum, input bin_column, input bin_row,
                   input frame_brightness, input last_bin, output ready);
endinterface

// ===== rtl/core/ibs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ibs_ram #(
   parameter int DATA_W = 20,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/image_bin_4x4_sum_and_brightness_top.sv =====
// 4x4 binning with frame brightness. Takes one 16-bit pixel per clock in raster
// order unless the result side stalls; one word per 4x4 block leaves through the
// stage 1 and output registers once its bottom-right pixel is accepted. The line
// store is read on a group's first pixel under a band's top row and written on the fourth.
// The line store needs no clearing after reset. Write the size registers only
// while the block is idle; values of zero are taken as one, oversize as the limit.
// Depends on ibs_pkg, ibs_req_if, ibs_rsp_if and ibs_ram.
module image_bin_4x4_sum_and_brightness_top #(
   parameter int MAX_BINNED_WIDTH = ibs_pkg::MAX_BINNED_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ibs_req_if.sink                          req,
   ibs_rsp_if.source                        rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ibs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ibs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ibs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int COL_W   = $clog2(4 * MAX_BINNED_WIDTH);
   localparam int ADDR_W  = (MAX_BINNED_WIDTH > 1) ? $clog2(MAX_BINNED_WIDTH) : 1;
   localparam int W_LIMIT = (MAX_BINNED_WIDTH > 1023) ? 1023 : MAX_BINNED_WIDTH;
   localparam int SUM_W   = ibs_pkg::SUM_W;
   localparam int GROUP_W = ibs_pkg::GROUP_W;
   localparam int CFG_W   = ibs_pkg::CFG_W;
   localparam int ROW_W   = ibs_pkg::ROW_W;
   localparam int POS_W   = ibs_pkg::POS_W;
   localparam int BRIGHT_W = ibs_pkg::BRIGHT_W;

   // configuration
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             csr_write;
   logic [CFG_W-1:0] width_eff, height_eff;

   // pixel position and group accumulation
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [GROUP_W-1:0] group_ff, group_in;

   logic               accept;
   logic               col_last, col_first, row_first, row_last;
   logic               row_end, frame_end;
   logic [COL_W:0]     col_count, col_limit;
   logic [ROW_W:0]     row_count, row_limit;
   logic [GROUP_W-1:0] group_sum;
   logic [SUM_W-1:0]   acc;
   logic [ADDR_W-1:0]  band;
   logic [SUM_W-1:0]   ram_rd_data;

   // result pipeline
   ibs_pkg::stage_type s1_ff, s1_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_load, s1_move, rsp_load;
   logic [BRIGHT_W-1:0] bright_ff, bright_in, bright_sum;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]    rsp_sum_ff;
   logic [POS_W-1:0]    rsp_column_ff;
   logic [POS_W-1:0]    rsp_row_ff;
   logic [BRIGHT_W-1:0] rsp_bright_ff;
   logic                rsp_last_ff;

   //------------------------------------------------------------------
   // Configuration port
   //------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (paddr[2])
            ibs_pkg::REG_BINNED_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            ibs_pkg::REG_BINNED_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         ibs_pkg::REG_BINNED_WIDTH:  prdata = ibs_pkg::CSR_DATA_W'(width_ff);
         ibs_pkg::REG_BINNED_HEIGHT: prdata = ibs_pkg::CSR_DATA_W'(height_ff);
         default:                    prdata = '0;
      endcase
   end

   always_comb begin
      if (width_ff == '0) begin
         width_eff = CFG_W'(1);
      end else if (32'(width_ff) > 32'(W_LIMIT)) begin
         width_eff = CFG_W'(W_LIMIT);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff == '0) begin
         height_eff = CFG_W'(1);
      end else if (32'(height_ff) > 32'(ibs_pkg::HEIGHT_LIMIT)) begin
         height_eff = CFG_W'(ibs_pkg::HEIGHT_LIMIT);
      end else begin
         height_eff = height_ff;
      end
   end

   //------------------------------------------------------------------
   // Pixel intake
   //------------------------------------------------------------------
   assign s1_move   = s1_valid_ff & (~s1_ff.emit | ~rsp_valid_ff | rsp.ready);
   assign req.ready = ~s1_valid_ff | s1_move;
   assign accept    = req.valid & req.ready;

   assign col_first = (col_ff[ibs_pkg::BIN_SHIFT-1:0] == ibs_pkg::BIN_FIRST);
   assign col_last  = (col_ff[ibs_pkg::BIN_SHIFT-1:0] == ibs_pkg::BIN_LAST);
   assign row_first = (row_ff[ibs_pkg::BIN_SHIFT-1:0] == ibs_pkg::BIN_FIRST);
   assign row_last  = (row_ff[ibs_pkg::BIN_SHIFT-1:0] == ibs_pkg::BIN_LAST);

   assign col_count = {1'b0, col_ff} + (COL_W+1)'(1);
   assign col_limit = (COL_W+1)'({width_eff, 2'b00});
   assign row_count = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign row_limit = (ROW_W+1)'({height_eff, 2'b00});
   assign row_end   = (col_count >= col_limit);
   assign frame_end = row_end & (row_count >= row_limit);

   assign band      = ADDR_W'(col_ff >> ibs_pkg::BIN_SHIFT);
   assign group_sum = group_ff + GROUP_W'(req.pixel);
   // first row of a band starts the entry fresh; others add to what is stored
   assign acc       = row_first ? SUM_W'(group_sum) : ram_rd_data + SUM_W'(group_sum);

   // Read the band entry on the group's first pixel below a band's top row; data holds until the fourth.
   ibs_ram #(
      .DATA_W (SUM_W),
      .DEPTH  (MAX_BINNED_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_band_ram (
      .clock   (clock),
      .wr_en   (accept & col_last),
      .wr_addr (band),
      .wr_data (acc),
      .rd_en   (accept & col_first & ~row_first),
      .rd_addr (band),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      group_in = group_ff;
      if (accept) begin
         group_in = col_last ? '0 : group_sum;
         if (row_end) begin
            // drop any partial group at the row end
            group_in = '0;
            col_in   = '0;
            row_in   = frame_end ? '0 : row_count[ROW_W-1:0];
         end else begin
            col_in = col_count[COL_W-1:0];
         end
      end
   end

   //------------------------------------------------------------------
   // Stage 1: finished block or frame end waits for the brightness add
   //------------------------------------------------------------------
   assign s1_load = accept & ((col_last & row_last) | frame_end);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_load) begin
         s1_valid_in  = 1'b1;
         s1_in.emit   = col_last & row_last;
         s1_in.last   = frame_end;
         s1_in.acc    = acc;
         s1_in.column = POS_W'(col_ff >> ibs_pkg::BIN_SHIFT);
         s1_in.row    = POS_W'(row_ff >> ibs_pkg::BIN_SHIFT);
      end
   end

   //------------------------------------------------------------------
   // Stage 2: brightness and output register
   //------------------------------------------------------------------
   assign rsp_load   = s1_move & s1_ff.emit;
   assign bright_sum = bright_ff + BRIGHT_W'(s1_ff.acc);

   always_comb begin
      bright_in = bright_ff;
      if (s1_move) begin
         if (s1_ff.last) begin
            bright_in = '0;
         end else if (s1_ff.emit) begin
            bright_in = bright_sum;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= CFG_W'(512);
         height_ff    <= CFG_W'(512);
         col_ff       <= '0;
         row_ff       <= '0;
         group_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         bright_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         group_ff     <= group_in;
         s1_valid_ff  <= s1_valid_in;
         bright_ff    <= bright_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (rsp_load) begin
         rsp_sum_ff    <= s1_ff.acc;
         rsp_column_ff <= s1_ff.column;
         rsp_row_ff    <= s1_ff.row;
         rsp_bright_ff <= bright_sum;
         rsp_last_ff   <= s1_ff.last;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.bin_sum          = rsp_sum_ff;
   assign rsp.bin_column       = rsp_column_ff;
   assign rsp.bin_row          = rsp_row_ff;
   assign rsp.frame_brightness = rsp_bright_ff;
   assign rsp.last_bin         = rsp_last_ff;

endmodule

// ===== dv/image_bin_4x4_sum_and_brightness_checker.sv =====
// Checker for the 4x4 binning block: watches pixel, bin and register traffic,
// predicts every bin word and compares it.
// Depends on ibs_pkg and both channel interfaces.
module image_bin_4x4_sum_and_brightness_checker #(
   parameter int MAX_BINNED_WIDTH = ibs_pkg::MAX_BINNED_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ibs_req_if                               req,
   ibs_rsp_if                               rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ibs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ibs_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic                             pready,
   output int                               mismatches,
   output int                               bins_pending,
   output int                               bins_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BIN_SHIFT = ibs_pkg::BIN_SHIFT;
   localparam int PIXEL_W   = ibs_pkg::PIXEL_W;
   localparam int GROUP_W   = ibs_pkg::GROUP_W;
   localparam int SUM_W     = ibs_pkg::SUM_W;
   localparam int POS_W     = ibs_pkg::POS_W;
   localparam int BRIGHT_W  = ibs_pkg::BRIGHT_W;
   localparam int CFG_W     = ibs_pkg::CFG_W;
   localparam int ROW_W     = ibs_pkg::ROW_W;

   localparam int BLOCK = 1 << BIN_SHIFT;
   localparam int REG_BIT = 2;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CFG_W-1:0] SIZE_AT_RESET = 10'd512;

   typedef struct packed {
      logic [SUM_W-1:0]    bin_sum;
      logic [POS_W-1:0]    column;
      logic [POS_W-1:0]    row;
      logic [BRIGHT_W-1:0] brightness;
      logic                last;
   } bin_word_type;

   logic [CFG_W-1:0]    width_reg;
   logic [CFG_W-1:0]    height_reg;
   logic [SUM_W-1:0]    band_sums [MAX_BINNED_WIDTH];
   logic [GROUP_W-1:0]  group_acc;
   logic [ROW_W-1:0]    col_pos;
   logic [ROW_W-1:0]    row_pos;
   logic [BRIGHT_W-1:0] brightness;
   bin_word_type        expected_bins[$];

   function automatic int size_limited(input logic [CFG_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   task automatic bin_pixel(input logic [PIXEL_W-1:0] px);
      int w_eff, h_eff, col, row, band;
      logic row_end, frame_end;
      logic [GROUP_W-1:0] group_sum;
      logic [SUM_W-1:0] acc;
      bin_word_type word;
      w_eff = size_limited(width_reg, MAX_BINNED_WIDTH);
      h_eff = size_limited(height_reg, ibs_pkg::HEIGHT_LIMIT);
      col = int'(col_pos);
      row = int'(row_pos);
      band = (col >> BIN_SHIFT) % MAX_BINNED_WIDTH;
      row_end = (col + 1) >= BLOCK * w_eff;
      frame_end = row_end && ((row + 1) >= BLOCK * h_eff);

      if (col_pos[BIN_SHIFT-1:0] == ibs_pkg::BIN_LAST) begin
         group_sum = group_acc + px;
         // top row of a band starts the line store entry afresh
         if (row_pos[BIN_SHIFT-1:0] == ibs_pkg::BIN_FIRST) acc = SUM_W'(group_sum);
         else acc = band_sums[band] + SUM_W'(group_sum);
         band_sums[band] = acc;
         group_acc = '0;
         if (row_pos[BIN_SHIFT-1:0] == ibs_pkg::BIN_LAST) begin
            brightness = brightness + BRIGHT_W'(acc);
            word.bin_sum = acc;
            word.column = POS_W'(col >> BIN_SHIFT);
            word.row = POS_W'(row >> BIN_SHIFT);
            word.brightness = brightness;
            word.last = frame_end;
            expected_bins.push_back(word);
         end
      end else begin
         group_acc = group_acc + px;
      end

      // drop a partial group at the row end; a frame end discards the total
      if (row_end) begin
         group_acc = '0;
         col_pos = '0;
         if (frame_end) begin
            row_pos = '0;
            brightness = '0;
         end else begin
            row_pos = ROW_W'(row + 1);
         end
      end else begin
         col_pos = ROW_W'(col + 1);
      end
   endtask

   task automatic check_bin();
      bin_word_type want;
      bit same;
      if (expected_bins.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%t unexpected bin word: sum %0d col %0d row %0d bright %0d last %0b",
                     $realtime, rsp.bin_sum, rsp.bin_column, rsp.bin_row,
                     rsp.frame_brightness, rsp.last_bin);
      end else begin
         want = expected_bins.pop_front();
         bins_checked++;
         same = (rsp.bin_sum === want.bin_sum) && (rsp.bin_column === want.column) &&
                (rsp.bin_row === want.row) && (rsp.frame_brightness === want.brightness) &&
                (rsp.last_bin === want.last);
         if (!same) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%t bin word expected: sum %0d col %0d row %0d bright %0d last %0b",
                        $realtime, want.bin_sum, want.column, want.row, want.brightness,
                        want.last);
               $display("%t            actual: sum %0d col %0d row %0d bright %0d last %0b",
                        $realtime, rsp.bin_sum, rsp.bin_column, rsp.bin_row,
                        rsp.frame_brightness, rsp.last_bin);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = SIZE_AT_RESET;
         height_reg = SIZE_AT_RESET;
         group_acc = '0;
         col_pos = '0;
         row_pos = '0;
         brightness = '0;
         expected_bins.delete();
      end else begin
         // compare first so a word cannot match a pixel taken on the same edge
         if (rsp.valid && rsp.ready) check_bin();
         if (req.valid && req.ready) bin_pixel(req.pixel);
         if (psel && penable && pwrite && pready) begin
            if (paddr[REG_BIT] == ibs_pkg::REG_BINNED_WIDTH) width_reg = pwdata[CFG_W-1:0];
            else height_reg = pwdata[CFG_W-1:0];
         end
      end
      bins_pending = expected_bins.size();
   end

endmodule

// ===== dv/image_bin_4x4_sum_and_brightness_top_test.sv =====
// Top of the 4x4 binning testbench: clock, reset, pixel and register stimulus,
// result back-pressure and the verdict.
// Depends on ibs_pkg, the channel interfaces, the block and its checker.
module image_bin_4x4_sum_and_brightness_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} pixel_fill_type;

   localparam int MAX_W = ibs_pkg::MAX_BINNED_WIDTH_DEF;
   localparam int BLOCK = 1 << ibs_pkg::BIN_SHIFT;
   localparam int PIXEL_W = ibs_pkg::PIXEL_W;
   localparam int CSR_DATA_W = ibs_pkg::CSR_DATA_W;
   localparam int HEIGHT_LIMIT = ibs_pkg::HEIGHT_LIMIT;
   localparam int ITEM_TARGET = 450;
   localparam int PHASE_COUNT = 4;
   localparam int PRESSURE_FRAME = 0;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;

   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [ibs_pkg::CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0]          pwdata;
   logic [CSR_DATA_W-1:0]          prdata;
   logic                           pready;

   ibs_req_if req ();
   ibs_rsp_if rsp ();

   idle_mode_type idle_mode = IDLE_NONE;
   int hold_requests = 0;
   int holds_done = 0;
   int cycles = 0;
   int pixels_sent = 0;
   int frame_setups = 0;
   int pos_col = 0;
   int pos_row = 0;
   int eff_w = MAX_W;
   int eff_h = HEIGHT_LIMIT;
   int mismatches;
   int bins_pending;
   int bins_checked;

   image_bin_4x4_sum_and_brightness_top #(.MAX_BINNED_WIDTH(MAX_W)) dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   image_bin_4x4_sum_and_brightness_checker #(.MAX_BINNED_WIDTH(MAX_W)) bin_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .pready       (pready),
      .mismatches   (mismatches),
      .bins_pending (bins_pending),
      .bins_checked (bins_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("image_bin_4x4_sum_and_brightness_top: mismatch");
         $finish;
      end
   end

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int sender_gap_pct();
      case (idle_mode)
         IDLE_SENDER: return 51;
         IDLE_BOTH:   return 33;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 51;
         IDLE_BOTH:     return 33;
         default:       return 0;
      endcase
   endfunction

   function automatic int effective_size(input int v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic logic [PIXEL_W-1:0] next_pixel(input pixel_fill_type fill);
      case (fill)
         FILL_ZERO: return '0;
         FILL_ONES: return '1;
         default: begin
            case ($urandom_range(7))
               0:       return '0;
               1:       return '1;
               default: return PIXEL_W'($urandom);
            endcase
         end
      endcase
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp.ready <= !chance(receiver_stall_pct());
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      if (chance(sender_gap_pct())) begin
         req.valid <= 1'b0;
         do @(negedge clock); while (chance(sender_gap_pct()));
      end
      req.valid <= 1'b1;
      req.pixel <= px;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      pixels_sent++;
      // track the raster position to know where frames and bands start
      if (pos_col + 1 >= BLOCK * eff_w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= BLOCK * eff_h) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   task automatic send_to_frame_end(input pixel_fill_type fill);
      do send_pixel(next_pixel(fill)); while (pos_col != 0 || pos_row != 0);
   endtask

   // drop valid, wait for every bin word, then give the pipeline time to drain
   task automatic settle();
      req.valid <= 1'b0;
      while (bins_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_size(input int w_value, input int h_value);
      logic idx;
      int value;
      for (int i = 0; i < 2; i++) begin
         idx = (i == 0) ? ibs_pkg::REG_BINNED_WIDTH : ibs_pkg::REG_BINNED_HEIGHT;
         value = (i == 0) ? w_value : h_value;
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {idx, 2'b00};
         pwdata <= CSR_DATA_W'(value);
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         @(negedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      eff_w = effective_size(w_value, MAX_W);
      eff_h = effective_size(h_value, HEIGHT_LIMIT);
      frame_setups++;
   endtask

   initial begin
      int frame_no;
      int w_pick;
      int h_pick;
      bit broken;

      reset = 1'b1;
      req.valid = 1'b0;
      req.pixel = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // oversize registers, then shrink to 1x1 in mid row: partial group dropped,
      // block of all-ones pixels gives the largest sum
      write_frame_size(1023, 1023);
      repeat (6) send_pixel(next_pixel(FILL_ONES));
      settle();
      write_frame_size(0, 1);
      send_to_frame_end(FILL_ONES);
      settle();

      // zero block, then cut the frame height so the frame ends off a block corner
      write_frame_size(1, 2);
      repeat (16) send_pixel(next_pixel(FILL_ZERO));
      repeat (2) send_pixel(next_pixel(FILL_RANDOM));
      settle();
      write_frame_size(1, 0);
      send_to_frame_end(FILL_RANDOM);

      // one frame per idle phase at least, then keep going until the pixel count is met
      frame_no = 0;
      while (pixels_sent < ITEM_TARGET || frame_no < PHASE_COUNT) begin
         settle();
         idle_mode = idle_mode_type'(frame_no % PHASE_COUNT);
         w_pick = $urandom_range(5);
         h_pick = $urandom_range(3);
         broken = ($urandom_range(4) == 0);
         if (frame_no == PRESSURE_FRAME) begin
            idle_mode = IDLE_NONE;
            w_pick = 4;
            h_pick = 3;
            broken = 1'b0;
         end
         // widen only on the top row of a band, so no line store entry is read unwritten
         if (pos_row % BLOCK != 0 && effective_size(w_pick, MAX_W) > eff_w) w_pick = eff_w;
         write_frame_size(w_pick, h_pick);
         if (frame_no == PRESSURE_FRAME) hold_requests++;
         if (broken) begin
            repeat ($urandom_range(1, 40)) send_pixel(next_pixel(FILL_RANDOM));
         end else begin
            send_to_frame_end(FILL_RANDOM);
         end
         frame_no++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run covered %0d pixels under %0d size settings and %0d bin words compared",
               pixels_sent, frame_setups, bins_checked);
      $display("sizes from zero to oversize, mid-frame size changes, one long result hold-off");
      if (mismatches == 0) begin
         $display("image_bin_4x4_sum_and_brightness_top: match");
      end else begin
         $display("image_bin_4x4_sum_and_brightness_top: mismatch");
      end
      $finish;
   end

endmodule
